// File: sv/grp_pkg.sv
// Shared constants for the guillotine rectangle packer: field widths, codes and register map.
package grp_pkg;

    // Fixed field widths of the command, result and configuration ports
    localparam int unsigned REQ_BITS    = 16;
    localparam int unsigned STATUS_BITS = 2;
    localparam int unsigned APB_DATA    = 32;
    localparam int unsigned APB_ADDR    = 3;

    // Status codes
    localparam logic [STATUS_BITS-1:0] STATUS_PLACED  = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_NO_FIT  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_CLEARED = 2'd3;

    // Action codes
    localparam logic ACTION_PACK  = 1'b0;
    localparam logic ACTION_CLEAR = 1'b1;

    // Register select (paddr bit 2)
    localparam logic REG_ATLAS_WIDTH  = 1'b0;
    localparam logic REG_ATLAS_HEIGHT = 1'b1;

    // Reset value of both atlas dimensions
    localparam logic [REQ_BITS-1:0] ATLAS_RESET = 16'd4096;

endpackage

// File: sv/grp_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module grp_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: sv/guillotine_rect_packer_core.sv
// Guillotine rectangle packer: free-rectangle list in RAM, scan/trim/split/compact sequencer.
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+-------------------------------
//  command   | in        | start && !busy            | action, req_width, req_height
//  result    | out       | done (one-cycle strobe)   | status, place_x, place_y
//  config    | in        | APB psel/penable/pwrite   | paddr, pwdata (prdata on read)
//
// Cycles: a pack takes 1 cycle to issue the first read plus one cycle per entry scanned
// (newest first, one RAM read per cycle), plus one cycle for a split (second write) or
// one cycle per entry moved when an exact fit closes up the list. A clear takes 1 cycle.
// done pulses the cycle after the last write; the next command can be taken in that cycle.
// Reset: after rst_n rises the block spends one cycle (busy high) writing the full atlas
// into entry zero. The receiver cannot stall; every transaction yields exactly one result.
module guillotine_rect_packer_core
    import grp_pkg::*;
#(
    parameter int unsigned MAX_FREE   = 64,
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // command
    input  logic                   start,
    output logic                   busy,
    input  logic                   action,
    input  logic [REQ_BITS-1:0]    req_width,
    input  logic [REQ_BITS-1:0]    req_height,
    // result
    output logic                   done,
    output logic [STATUS_BITS-1:0] status,
    output logic [REQ_BITS-1:0]    place_x,
    output logic [REQ_BITS-1:0]    place_y,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR-1:0]    paddr,
    input  logic [APB_DATA-1:0]    pwdata,
    output logic [APB_DATA-1:0]    prdata,
    output logic                   pready
);

    localparam int unsigned C  = COORD_BITS;
    localparam int unsigned EW = 4 * C;
    localparam int unsigned AW = $clog2(MAX_FREE);
    localparam int unsigned CW = $clog2(MAX_FREE + 1);
    localparam logic [C-1:0]  COORD_MAX = {C{1'b1}};
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_FREE);

    // Sequencer states
    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_APPEND = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [REQ_BITS-1:0]    rw_reg, rw_next;
    logic [REQ_BITS-1:0]    rh_reg, rh_next;
    logic [EW-1:0]          app_reg, app_next;
    logic [REQ_BITS-1:0]    atlas_w_reg, atlas_h_reg;
    logic                   done_reg, done_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;
    logic [REQ_BITS-1:0]    px_reg, px_next;
    logic [REQ_BITS-1:0]    py_reg, py_next;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [EW-1:0]          mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [EW-1:0]          mem_rdata;

    logic [C-1:0]           ex, ey, ew, eh;
    logic [C-1:0]           rwc, rhc;
    logic                   fits, w_full, h_full;
    logic [C-1:0]           sat_w, sat_h;
    logic                   cfg_wr;

    // Free-rectangle list: {x, y, w, h}
    grp_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_FREE)
    ) u_free_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ATLAS_HEIGHT) ? APB_DATA'(atlas_h_reg)
                                                   : APB_DATA'(atlas_w_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_w_reg <= ATLAS_RESET;
            atlas_h_reg <= ATLAS_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_ATLAS_WIDTH)
            begin
                atlas_w_reg <= pwdata[REQ_BITS-1:0];
            end
            else
            begin
                atlas_h_reg <= pwdata[REQ_BITS-1:0];
            end
        end
    end

    // Atlas size saturated to the coordinate range
    assign sat_w = (atlas_w_reg > REQ_BITS'(COORD_MAX)) ? COORD_MAX : atlas_w_reg[C-1:0];
    assign sat_h = (atlas_h_reg > REQ_BITS'(COORD_MAX)) ? COORD_MAX : atlas_h_reg[C-1:0];

    // Fields of the entry being examined
    assign ex  = mem_rdata[4*C-1:3*C];
    assign ey  = mem_rdata[3*C-1:2*C];
    assign ew  = mem_rdata[2*C-1:C];
    assign eh  = mem_rdata[C-1:0];
    assign rwc = rw_reg[C-1:0];
    assign rhc = rh_reg[C-1:0];

    assign fits   = (REQ_BITS'(ew) >= rw_reg) && (REQ_BITS'(eh) >= rh_reg);
    assign w_full = (REQ_BITS'(ew) == rw_reg);
    assign h_full = (REQ_BITS'(eh) == rh_reg);

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        rw_next     = rw_reg;
        rh_next     = rh_reg;
        app_next    = app_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = mem_rdata;
        mem_raddr   = idx_reg;

        unique case (state_reg)
            S_INIT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = {{(2*C){1'b0}}, sat_w, sat_h};
                count_next = CW'(1);
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (start)
                begin
                    rw_next = req_width;
                    rh_next = req_height;
                    px_next = '0;
                    py_next = '0;
                    if (action == ACTION_CLEAR)
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = '0;
                        mem_wdata   = {{(2*C){1'b0}}, sat_w, sat_h};
                        count_next  = CW'(1);
                        done_next   = 1'b1;
                        status_next = STATUS_CLEARED;
                    end
                    else if (count_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_NO_FIT;
                    end
                    else
                    begin
                        idx_next   = AW'(count_reg - CW'(1));
                        mem_raddr  = AW'(count_reg - CW'(1));
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (!fits)
                begin
                    if (idx_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_NO_FIT;
                        px_next     = '0;
                        py_next     = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        idx_next  = idx_reg - AW'(1);
                        mem_raddr = idx_reg - AW'(1);
                    end
                end
                else if (w_full && h_full)
                begin
                    px_next = REQ_BITS'(ex);
                    py_next = REQ_BITS'(ey);
                    if ((CW'(idx_reg) + CW'(1)) < count_reg)
                    begin
                        // close up: read the next-newer entry, write it one slot down
                        mem_raddr  = AW'(CW'(idx_reg) + CW'(1));
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        count_next  = count_reg - CW'(1);
                        done_next   = 1'b1;
                        status_next = STATUS_PLACED;
                        state_next  = S_IDLE;
                    end
                end
                else if (w_full)
                begin
                    mem_we      = 1'b1;
                    mem_wdata   = {ex, ey + rhc, ew, eh - rhc};
                    px_next     = REQ_BITS'(ex);
                    py_next     = REQ_BITS'(ey);
                    done_next   = 1'b1;
                    status_next = STATUS_PLACED;
                    state_next  = S_IDLE;
                end
                else if (h_full)
                begin
                    mem_we      = 1'b1;
                    mem_wdata   = {ex + rwc, ey, ew - rwc, eh};
                    px_next     = REQ_BITS'(ex);
                    py_next     = REQ_BITS'(ey);
                    done_next   = 1'b1;
                    status_next = STATUS_PLACED;
                    state_next  = S_IDLE;
                end
                else if (count_reg >= COUNT_MAX)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_FULL;
                    px_next     = '0;
                    py_next     = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    // split: trim entry upward now, append right-hand piece next cycle
                    mem_we     = 1'b1;
                    mem_wdata  = {ex, ey + rhc, ew, eh - rhc};
                    app_next   = {ex + rwc, ey, ew - rwc, rhc};
                    px_next    = REQ_BITS'(ex);
                    py_next    = REQ_BITS'(ey);
                    state_next = S_APPEND;
                end
            end

            S_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                if ((CW'(idx_reg) + CW'(2)) < count_reg)
                begin
                    idx_next  = idx_reg + AW'(1);
                    mem_raddr = AW'(CW'(idx_reg) + CW'(2));
                end
                else
                begin
                    count_next  = count_reg - CW'(1);
                    done_next   = 1'b1;
                    status_next = STATUS_PLACED;
                    state_next  = S_IDLE;
                end
            end

            S_APPEND:
            begin
                mem_we      = 1'b1;
                mem_waddr   = count_reg[AW-1:0];
                mem_wdata   = app_reg;
                count_next  = count_reg + CW'(1);
                done_next   = 1'b1;
                status_next = STATUS_PLACED;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            count_reg <= CW'(1);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        rw_reg     <= rw_next;
        rh_reg     <= rh_next;
        app_reg    <= app_next;
        status_reg <= status_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign status  = status_reg;
    assign place_x = px_reg;
    assign place_y = py_reg;

endmodule
